// ===== src/emcr_pkg.sv =====
// Shared widths and pipeline payload types for the equal-mass collision response block.
package emcr_pkg;

    localparam int DATA_W      = 32;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int HI_W        = SUM_W - MAG_W;
    localparam int HI_PROD_W   = HI_W + MAG_W;
    localparam int NUM_W       = SUM_W + MAG_W;
    localparam int QUOT_W      = 34;
    localparam int REM_W       = SUM_W;
    localparam int ACC_W       = 36;
    localparam int IN_TDATA_W  = 8 * DATA_W;
    localparam int OUT_TDATA_W = 4 * DATA_W;
    localparam int OUT_TUSER_W = 2;

    // Velocities and the coincidence flag ride alongside the arithmetic.
    typedef struct packed {
        logic signed [DATA_W-1:0] vel_a_x;
        logic signed [DATA_W-1:0] vel_a_y;
        logic signed [DATA_W-1:0] vel_b_x;
        logic signed [DATA_W-1:0] vel_b_y;
        logic                     coincide;
    } emcr_side_t;

    // State of one request inside the restoring divider.
    typedef struct packed {
        emcr_side_t          side;
        logic                neg_x;
        logic                neg_y;
        logic [REM_W-1:0]    divisor;
        logic [REM_W-1:0]    rem_x;
        logic [REM_W-1:0]    rem_y;
        logic [QUOT_W-1:0]   quot_x;
        logic [QUOT_W-1:0]   quot_y;
        logic [QUOT_W-1:0]   numer_x;
        logic [QUOT_W-1:0]   numer_y;
    } emcr_div_t;

endpackage

// ===== src/emcr_div_stage.sv =====
// One registered restoring-division step for both velocity components.
module emcr_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  emcr_pkg::emcr_div_t in_data,
    output logic               out_valid,
    output emcr_pkg::emcr_div_t out_data
);
    import emcr_pkg::*;

    logic                valid_reg;
    emcr_div_t           data_reg;
    emcr_div_t           data_next;
    logic [REM_W+1:0]    trial_x;
    logic [REM_W+1:0]    trial_y;

    // Shift in the next numerator bit and subtract the divisor where it fits.
    always_comb
    begin
        data_next = in_data;
        trial_x   = {1'b0, in_data.rem_x, in_data.numer_x[QUOT_W-1]} - {2'b00, in_data.divisor};
        trial_y   = {1'b0, in_data.rem_y, in_data.numer_y[QUOT_W-1]} - {2'b00, in_data.divisor};
        data_next.numer_x = {in_data.numer_x[QUOT_W-2:0], 1'b0};
        data_next.numer_y = {in_data.numer_y[QUOT_W-2:0], 1'b0};
        data_next.quot_x  = {in_data.quot_x[QUOT_W-2:0], ~trial_x[REM_W+1]};
        data_next.quot_y  = {in_data.quot_y[QUOT_W-2:0], ~trial_y[REM_W+1]};
        if (trial_x[REM_W+1])
        begin
            data_next.rem_x = {in_data.rem_x[REM_W-2:0], in_data.numer_x[QUOT_W-1]};
        end
        else
        begin
            data_next.rem_x = trial_x[REM_W-1:0];
        end
        if (trial_y[REM_W+1])
        begin
            data_next.rem_y = {in_data.rem_y[REM_W-2:0], in_data.numer_y[QUOT_W-1]};
        end
        else
        begin
            data_next.rem_y = trial_y[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/equal_mass_collision_response.sv =====
// Top level: elastic collision response of two equal-mass discs, fully pipelined.
// Throughput: one request per cycle unless m_tready stalls the output.
// 41 register stages, 34 of them a radix-2 divider.
// Back-pressure collapses bubbles, so s_tready stays high while any stage is empty.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
// The Q16.16 scale cancels in the projection ratio, so any fractional split gives the same bits.
module equal_mass_collision_response (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ball_a_x, ball_a_y, ball_b_x, ball_b_y, vel_a_x, vel_a_y, vel_b_x, vel_b_y
    input  logic [emcr_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
    output logic [emcr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // centers_coincide, clipped
    output logic [emcr_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import emcr_pkg::*;

    // Returns {negative, magnitude} of minuend - subtrahend. Both orders are
    // formed side by side so the magnitude costs a single adder level.
    function automatic logic [MAG_W:0] mag_diff(
        input logic signed [DATA_W-1:0] minuend,
        input logic signed [DATA_W-1:0] subtrahend
    );
        logic signed [DATA_W:0] fwd;
        logic signed [DATA_W:0] rev;
        fwd = (DATA_W+1)'(minuend) - (DATA_W+1)'(subtrahend);
        rev = (DATA_W+1)'(subtrahend) - (DATA_W+1)'(minuend);
        return {fwd[DATA_W], fwd[DATA_W] ? rev[MAG_W-1:0] : fwd[MAG_W-1:0]};
    endfunction

    // Returns {clipped, value} of a wide signed sum clamped to 32 bits.
    function automatic logic [DATA_W:0] saturate(input logic signed [ACC_W-1:0] value);
        logic ovf;
        ovf = (value[ACC_W-1:DATA_W-1] != '0) && (value[ACC_W-1:DATA_W-1] != '1);
        if (!ovf)
        begin
            return {1'b0, value[DATA_W-1:0]};
        end
        return {1'b1, value[ACC_W-1], {(DATA_W-1){~value[ACC_W-1]}}};
    endfunction

    // Request fields.
    logic signed [DATA_W-1:0] ball_a_x;
    logic signed [DATA_W-1:0] ball_a_y;
    logic signed [DATA_W-1:0] ball_b_x;
    logic signed [DATA_W-1:0] ball_b_y;
    logic signed [DATA_W-1:0] vel_a_x;
    logic signed [DATA_W-1:0] vel_a_y;
    logic signed [DATA_W-1:0] vel_b_x;
    logic signed [DATA_W-1:0] vel_b_y;

    assign ball_a_x = s_tdata[0*DATA_W +: DATA_W];
    assign ball_a_y = s_tdata[1*DATA_W +: DATA_W];
    assign ball_b_x = s_tdata[2*DATA_W +: DATA_W];
    assign ball_b_y = s_tdata[3*DATA_W +: DATA_W];
    assign vel_a_x  = s_tdata[4*DATA_W +: DATA_W];
    assign vel_a_y  = s_tdata[5*DATA_W +: DATA_W];
    assign vel_b_x  = s_tdata[6*DATA_W +: DATA_W];
    assign vel_b_y  = s_tdata[7*DATA_W +: DATA_W];

    // Stage enables. A stage loads when it is empty or its successor moves,
    // which lets bubbles be squeezed out while the output is stalled.
    logic s1_en, s2_en, s3_en, s4_en, s5_en, rnd_en, out_en;
    logic div_en    [0:QUOT_W];
    logic div_valid [0:QUOT_W];
    emcr_div_t div_data [0:QUOT_W];

    // Stage 1: center and velocity differences as sign and magnitude.
    logic                s1_valid_reg;
    logic [MAG_W-1:0]    s1_mag_dx_reg, s1_mag_dy_reg, s1_mag_dvx_reg, s1_mag_dvy_reg;
    logic                s1_neg_dx_reg, s1_neg_dy_reg, s1_neg_tx_reg, s1_neg_ty_reg;
    emcr_side_t          s1_side_reg;
    logic [MAG_W:0]      dx_next, dy_next, dvx_next, dvy_next;

    // Stage 2: squares of the center difference and the two dot-product terms.
    logic                s2_valid_reg;
    logic [PROD_W-1:0]   s2_sq_x_reg, s2_sq_y_reg, s2_tx_reg, s2_ty_reg;
    logic [MAG_W-1:0]    s2_mag_dx_reg, s2_mag_dy_reg;
    logic                s2_neg_dx_reg, s2_neg_dy_reg, s2_neg_tx_reg, s2_neg_ty_reg;
    emcr_side_t          s2_side_reg;

    // Stage 3: squared distance and signed dot product.
    logic                s3_valid_reg;
    logic [SUM_W-1:0]    s3_dd_reg, s3_dot_reg;
    logic [MAG_W-1:0]    s3_mag_dx_reg, s3_mag_dy_reg;
    logic                s3_neg_x_reg, s3_neg_y_reg;
    emcr_side_t          s3_side_reg;
    logic [SUM_W-1:0]    dot_sum, dot_diff, dot_rdiff, dot_next;
    logic                dot_neg_next;

    // Stage 4: partial products of dot * |d| per component.
    logic                s4_valid_reg;
    logic [PROD_W-1:0]   s4_lo_x_reg, s4_lo_y_reg;
    logic [HI_PROD_W-1:0] s4_hi_x_reg, s4_hi_y_reg;
    logic [SUM_W-1:0]    s4_dd_reg;
    logic                s4_neg_x_reg, s4_neg_y_reg;
    emcr_side_t          s4_side_reg;

    // Stage 5: full numerators, loaded as the divider's starting state.
    logic                s5_valid_reg;
    emcr_div_t           s5_data_reg;
    emcr_div_t           s5_data_next;
    logic [NUM_W-1:0]    num_x, num_y;

    // Round stage and output register.
    logic                rnd_valid_reg;
    logic [QUOT_W-1:0]   rnd_qm_x_reg, rnd_qm_y_reg;
    logic                rnd_neg_x_reg, rnd_neg_y_reg;
    emcr_side_t          rnd_side_reg;
    logic [QUOT_W:0]     inc_x, inc_y;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_a_x_reg, out_a_y_reg, out_b_x_reg, out_b_y_reg;
    logic                out_coincide_reg, out_clipped_reg;
    logic signed [ACC_W-1:0] qx_s, qy_s;
    logic signed [ACC_W-1:0] acc_a_x, acc_a_y, acc_b_x, acc_b_y;
    logic [DATA_W:0]     sat_a_x, sat_a_y, sat_b_x, sat_b_y;

    assign out_en = !out_valid_reg || m_tready;
    assign rnd_en = !rnd_valid_reg || out_en;
    assign div_en[QUOT_W] = rnd_en;
    assign s5_en  = !s5_valid_reg || div_en[0];
    assign s4_en  = !s4_valid_reg || s5_en;
    assign s3_en  = !s3_valid_reg || s4_en;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;

    assign dx_next  = mag_diff(ball_b_x, ball_a_x);
    assign dy_next  = mag_diff(ball_b_y, ball_a_y);
    assign dvx_next = mag_diff(vel_b_x, vel_a_x);
    assign dvy_next = mag_diff(vel_b_y, vel_a_y);

    // The dot product's magnitude: add when both terms share a sign, otherwise
    // keep whichever difference does not borrow.
    always_comb
    begin
        dot_sum   = {1'b0, s2_tx_reg} + {1'b0, s2_ty_reg};
        dot_diff  = {1'b0, s2_tx_reg} - {1'b0, s2_ty_reg};
        dot_rdiff = {1'b0, s2_ty_reg} - {1'b0, s2_tx_reg};
        priority if (s2_neg_tx_reg == s2_neg_ty_reg)
        begin
            dot_next     = dot_sum;
            dot_neg_next = s2_neg_tx_reg;
        end
        else if (!dot_diff[SUM_W-1])
        begin
            dot_next     = dot_diff;
            dot_neg_next = s2_neg_tx_reg;
        end
        else
        begin
            dot_next     = dot_rdiff;
            dot_neg_next = s2_neg_ty_reg;
        end
    end

    // Twice the numerator feeds the divider so that its last quotient bit is
    // the half used for rounding. The top part starts as the remainder; the
    // bound |correction| <= |v2 - v1| keeps it below the divisor.
    always_comb
    begin
        num_x = {s4_hi_x_reg, {MAG_W{1'b0}}} + NUM_W'(s4_lo_x_reg);
        num_y = {s4_hi_y_reg, {MAG_W{1'b0}}} + NUM_W'(s4_lo_y_reg);
        s5_data_next.side    = s4_side_reg;
        s5_data_next.neg_x   = s4_neg_x_reg;
        s5_data_next.neg_y   = s4_neg_y_reg;
        s5_data_next.divisor = s4_dd_reg;
        s5_data_next.rem_x   = REM_W'(num_x[NUM_W-1:QUOT_W-1]);
        s5_data_next.rem_y   = REM_W'(num_y[NUM_W-1:QUOT_W-1]);
        s5_data_next.quot_x  = '0;
        s5_data_next.quot_y  = '0;
        s5_data_next.numer_x = {num_x[QUOT_W-2:0], 1'b0};
        s5_data_next.numer_y = {num_y[QUOT_W-2:0], 1'b0};
    end

    assign div_valid[0] = s5_valid_reg;
    assign div_data[0]  = s5_data_reg;

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        assign div_en[k] = !div_valid[k+1] || div_en[k+1];

        emcr_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (div_en[k]),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // Round half away from zero on the magnitude: (2q + half + 1) / 2.
    assign inc_x = {1'b0, div_data[QUOT_W].quot_x} + (QUOT_W+1)'(1);
    assign inc_y = {1'b0, div_data[QUOT_W].quot_y} + (QUOT_W+1)'(1);

    // Apply the correction with its sign folded into the add or subtract.
    always_comb
    begin
        qx_s    = $signed({{(ACC_W-QUOT_W){1'b0}}, rnd_qm_x_reg});
        qy_s    = $signed({{(ACC_W-QUOT_W){1'b0}}, rnd_qm_y_reg});
        acc_a_x = rnd_neg_x_reg ? ACC_W'(rnd_side_reg.vel_a_x) - qx_s
                                : ACC_W'(rnd_side_reg.vel_a_x) + qx_s;
        acc_a_y = rnd_neg_y_reg ? ACC_W'(rnd_side_reg.vel_a_y) - qy_s
                                : ACC_W'(rnd_side_reg.vel_a_y) + qy_s;
        acc_b_x = rnd_neg_x_reg ? ACC_W'(rnd_side_reg.vel_b_x) + qx_s
                                : ACC_W'(rnd_side_reg.vel_b_x) - qx_s;
        acc_b_y = rnd_neg_y_reg ? ACC_W'(rnd_side_reg.vel_b_y) + qy_s
                                : ACC_W'(rnd_side_reg.vel_b_y) - qy_s;
        sat_a_x = saturate(acc_a_x);
        sat_a_y = saturate(acc_a_y);
        sat_b_x = saturate(acc_b_x);
        sat_b_y = saturate(acc_b_y);
    end

    // Valid bits of the top-level stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_en)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (rnd_en)
            begin
                rnd_valid_reg <= div_valid[QUOT_W];
            end
            if (out_en)
            begin
                out_valid_reg <= rnd_valid_reg;
            end
        end
    end

    // Payload registers load only with a valid request and carry no reset.
    always_ff @(posedge clk)
    begin
        if (s1_en && s_tvalid)
        begin
            s1_mag_dx_reg        <= dx_next[MAG_W-1:0];
            s1_mag_dy_reg        <= dy_next[MAG_W-1:0];
            s1_mag_dvx_reg       <= dvx_next[MAG_W-1:0];
            s1_mag_dvy_reg       <= dvy_next[MAG_W-1:0];
            s1_neg_dx_reg        <= dx_next[MAG_W];
            s1_neg_dy_reg        <= dy_next[MAG_W];
            s1_neg_tx_reg        <= dvx_next[MAG_W] ^ dx_next[MAG_W];
            s1_neg_ty_reg        <= dvy_next[MAG_W] ^ dy_next[MAG_W];
            s1_side_reg.vel_a_x  <= vel_a_x;
            s1_side_reg.vel_a_y  <= vel_a_y;
            s1_side_reg.vel_b_x  <= vel_b_x;
            s1_side_reg.vel_b_y  <= vel_b_y;
            s1_side_reg.coincide <= (ball_a_x == ball_b_x) && (ball_a_y == ball_b_y);
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_sq_x_reg   <= PROD_W'(s1_mag_dx_reg) * PROD_W'(s1_mag_dx_reg);
            s2_sq_y_reg   <= PROD_W'(s1_mag_dy_reg) * PROD_W'(s1_mag_dy_reg);
            s2_tx_reg     <= PROD_W'(s1_mag_dvx_reg) * PROD_W'(s1_mag_dx_reg);
            s2_ty_reg     <= PROD_W'(s1_mag_dvy_reg) * PROD_W'(s1_mag_dy_reg);
            s2_mag_dx_reg <= s1_mag_dx_reg;
            s2_mag_dy_reg <= s1_mag_dy_reg;
            s2_neg_dx_reg <= s1_neg_dx_reg;
            s2_neg_dy_reg <= s1_neg_dy_reg;
            s2_neg_tx_reg <= s1_neg_tx_reg;
            s2_neg_ty_reg <= s1_neg_ty_reg;
            s2_side_reg   <= s1_side_reg;
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_dd_reg     <= {1'b0, s2_sq_x_reg} + {1'b0, s2_sq_y_reg};
            s3_dot_reg    <= dot_next;
            s3_mag_dx_reg <= s2_mag_dx_reg;
            s3_mag_dy_reg <= s2_mag_dy_reg;
            s3_neg_x_reg  <= dot_neg_next ^ s2_neg_dx_reg;
            s3_neg_y_reg  <= dot_neg_next ^ s2_neg_dy_reg;
            s3_side_reg   <= s2_side_reg;
        end
        if (s4_en && s3_valid_reg)
        begin
            s4_lo_x_reg  <= PROD_W'(s3_dot_reg[MAG_W-1:0]) * PROD_W'(s3_mag_dx_reg);
            s4_lo_y_reg  <= PROD_W'(s3_dot_reg[MAG_W-1:0]) * PROD_W'(s3_mag_dy_reg);
            s4_hi_x_reg  <= HI_PROD_W'(s3_dot_reg[SUM_W-1:MAG_W]) * HI_PROD_W'(s3_mag_dx_reg);
            s4_hi_y_reg  <= HI_PROD_W'(s3_dot_reg[SUM_W-1:MAG_W]) * HI_PROD_W'(s3_mag_dy_reg);
            s4_dd_reg    <= s3_dd_reg;
            s4_neg_x_reg <= s3_neg_x_reg;
            s4_neg_y_reg <= s3_neg_y_reg;
            s4_side_reg  <= s3_side_reg;
        end
        if (s5_en && s4_valid_reg)
        begin
            s5_data_reg <= s5_data_next;
        end
        if (rnd_en && div_valid[QUOT_W])
        begin
            rnd_qm_x_reg  <= inc_x[QUOT_W:1];
            rnd_qm_y_reg  <= inc_y[QUOT_W:1];
            rnd_neg_x_reg <= div_data[QUOT_W].neg_x;
            rnd_neg_y_reg <= div_data[QUOT_W].neg_y;
            rnd_side_reg  <= div_data[QUOT_W].side;
        end
        if (out_en && rnd_valid_reg)
        begin
            out_coincide_reg <= rnd_side_reg.coincide;
            // Coinciding centers pass the velocities through unchanged.
            if (rnd_side_reg.coincide)
            begin
                out_a_x_reg     <= rnd_side_reg.vel_a_x;
                out_a_y_reg     <= rnd_side_reg.vel_a_y;
                out_b_x_reg     <= rnd_side_reg.vel_b_x;
                out_b_y_reg     <= rnd_side_reg.vel_b_y;
                out_clipped_reg <= 1'b0;
            end
            else
            begin
                out_a_x_reg     <= sat_a_x[DATA_W-1:0];
                out_a_y_reg     <= sat_a_y[DATA_W-1:0];
                out_b_x_reg     <= sat_b_x[DATA_W-1:0];
                out_b_y_reg     <= sat_b_y[DATA_W-1:0];
                out_clipped_reg <= sat_a_x[DATA_W] | sat_a_y[DATA_W] |
                                   sat_b_x[DATA_W] | sat_b_y[DATA_W];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_b_y_reg, out_b_x_reg, out_a_y_reg, out_a_x_reg};
    assign m_tuser  = {out_clipped_reg, out_coincide_reg};

    // An empty first stage must always take a new request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stage empty but request refused");

    // The divider's partial remainder stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[QUOT_W] && !div_data[QUOT_W].side.coincide
        |-> (div_data[QUOT_W].rem_x < div_data[QUOT_W].divisor) &&
            (div_data[QUOT_W].rem_y < div_data[QUOT_W].divisor))
        else $error("division remainder out of range");

    // The rounded correction never exceeds the relative speed, below 2^33.
    a_correction_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_valid_reg && !rnd_side_reg.coincide
        |-> !rnd_qm_x_reg[QUOT_W-1] && !rnd_qm_y_reg[QUOT_W-1])
        else $error("correction magnitude out of range");

    // A pass-through result is never marked as saturated.
    a_coincide_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_coincide_reg |-> !out_clipped_reg)
        else $error("coinciding centers reported as clipped");

endmodule
